### rtl/lgoc_pkg.sv
// ----------------------------------------------------------------------------
// lgoc_pkg
// Shared types, constants and the arctangent table of the ground overlay
// classifier.
// ----------------------------------------------------------------------------
package lgoc_pkg;

	localparam int MAX_WIDTH       = 4096;
	localparam int MAX_HEIGHT      = 256;
	localparam int SINE_ITERATIONS = 16;

	localparam int ITER_W = $clog2(SINE_ITERATIONS);

	// divider: dividend, divisor and step count widths
	localparam int DIV_W  = 35;
	localparam int DIVR_W = 17;
	localparam int STEP_W = 6;

	localparam logic [STEP_W-1:0] ANGLE_DIV_STEPS = STEP_W'(35);
	localparam logic [STEP_W-1:0] GREY_DIV_STEPS  = STEP_W'(24);

	// angle constants, Q3.28 radians
	localparam logic signed [31:0] ANGLE_MIN   = -32'sd116658555;
	localparam logic [26:0]        ANGLE_SPAN  = 27'd126028720;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd163008219;

	// register indexes
	localparam logic [2:0] REG_WIDTH     = 3'd0;
	localparam logic [2:0] REG_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_NZ_THRESH = 3'd2;
	localparam logic [2:0] REG_HT_THRESH = 3'd3;
	localparam logic [2:0] REG_RNG_FLOOR = 3'd4;
	localparam logic [2:0] REG_RNG_CEIL  = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANG,
		ST_ADIV,
		ST_CORD,
		ST_CLASS,
		ST_GDIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic signed [31:0] atan_q28(input logic [4:0] idx);
		logic signed [31:0] v;
		case (idx)
			5'd0:  v = 32'sd210828714;
			5'd1:  v = 32'sd124459457;
			5'd2:  v = 32'sd65760959;
			5'd3:  v = 32'sd33381290;
			5'd4:  v = 32'sd16755422;
			5'd5:  v = 32'sd8385879;
			5'd6:  v = 32'sd4193963;
			5'd7:  v = 32'sd2097109;
			5'd8:  v = 32'sd1048571;
			5'd9:  v = 32'sd524287;
			5'd10: v = 32'sd262144;
			5'd11: v = 32'sd131072;
			5'd12: v = 32'sd65536;
			5'd13: v = 32'sd32768;
			5'd14: v = 32'sd16384;
			5'd15: v = 32'sd8192;
			5'd16: v = 32'sd4096;
			5'd17: v = 32'sd2048;
			5'd18: v = 32'sd1024;
			5'd19: v = 32'sd512;
			5'd20: v = 32'sd256;
			5'd21: v = 32'sd128;
			5'd22: v = 32'sd64;
			5'd23: v = 32'sd32;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

### rtl/lgoc_div.sv
// ----------------------------------------------------------------------------
// lgoc_div
// Restoring unsigned divider, one quotient bit per cycle. The dividend is
// left-aligned; after N steps the low N bits of the quotient are valid.
// ----------------------------------------------------------------------------
module lgoc_div
	import lgoc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  div_req_t          req,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [DIVR_W-1:0] divisor,
	output unit_stat_t        stat,
	output logic [DIV_W-1:0]  quotient
);

	logic [DIV_W-1:0]  quot_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVR_W-1:0] dvsr_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVR_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quot_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q  <= DIVR_W'(trial - {1'b0, dvsr_q});
				quot_q <= {quot_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial[DIVR_W-1:0];
				quot_q <= {quot_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quot_q;

endmodule

### rtl/lgoc_cordic.sv
// ----------------------------------------------------------------------------
// lgoc_cordic
// Rotation-mode CORDIC, one micro-rotation per cycle; gives the sine of a
// Q3.28 angle rounded and saturated to Q1.15.
// ----------------------------------------------------------------------------
module lgoc_cordic
	import lgoc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] angle,
	output unit_stat_t         stat,
	output logic signed [15:0] sine
);

	logic signed [31:0] x_q, y_q, z_q;
	logic [ITER_W-1:0]  cnt_q;
	logic               busy_q;
	logic               done_q;
	logic signed [31:0] dx, dy, at;
	logic signed [32:0] y_rnd;
	logic signed [32:0] y_sh;

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign at = atan_q28(5'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ITER_W'(SINE_ITERATIONS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_GAIN;
			y_q <= '0;
			z_q <= angle;
		end else if (busy_q) begin
			if (!z_q[31]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	// round to Q1.15 and saturate
	assign y_rnd = {y_q[31], y_q} + 33'sd4096;
	assign y_sh  = y_rnd >>> 13;

	always_comb begin
		if (y_sh > 33'sd32767)
			sine = 16'sh7fff;
		else if (y_sh < -33'sd32768)
			sine = 16'sh8000;
		else
			sine = y_sh[15:0];
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### rtl/lidar_ground_overlay_classifier_unit.sv
// ----------------------------------------------------------------------------
// lidar_ground_overlay_classifier_unit
// Classifies range-image pixels as ground (orange) or grey and counts
// raster position; one sequencer drives a shared divider and a CORDIC.
// ----------------------------------------------------------------------------
// Sequencing: a plain pixel goes straight to classification; a range grey that
//   needs the divider adds a 24-step divide, and the first pixel of a row first
//   runs a 35-step angle divide, then 16 CORDIC rotations.
// Throughput: one item at a time; pixel_stall is high until the sequencer
//   has handed its result to the output register.
// Reset: registers take their defaults, column and row counts clear, the
//   output register is empty.
module lidar_ground_overlay_classifier_unit
	import lgoc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// pixel channel
	input  logic               pixel_valid,
	output logic               pixel_stall,
	input  logic               normal_valid,
	input  logic signed [15:0] normal_z,
	input  logic signed [15:0] range_value,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               ground_flag,
	output logic               frame_end,
	// register writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	// ---------------------------------------------------------------- config
	logic [12:0]        image_width_q;
	logic [8:0]         image_height_q;
	logic signed [15:0] nz_thresh_q;
	logic signed [15:0] ht_thresh_q;
	logic signed [15:0] rng_floor_q;
	logic signed [15:0] rng_ceil_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 13'd2048;
			image_height_q <= 9'd64;
			nz_thresh_q    <= 16'sd14746;
			ht_thresh_q    <= -16'sd384;
			rng_floor_q    <= 16'sd0;
			rng_ceil_q     <= 16'sd25600;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:     image_width_q  <= cfg_data[12:0];
				REG_HEIGHT:    image_height_q <= cfg_data[8:0];
				REG_NZ_THRESH: nz_thresh_q    <= cfg_data;
				REG_HT_THRESH: ht_thresh_q    <= cfg_data;
				REG_RNG_FLOOR: rng_floor_q    <= cfg_data;
				REG_RNG_CEIL:  rng_ceil_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective image size: width clamped to 1..MAX_WIDTH, height 2..MAX_HEIGHT.
	logic [12:0] width_eff;
	logic [8:0]  height_eff;
	logic [11:0] col_last;
	logic [7:0]  row_last;

	always_comb begin
		if (image_width_q == 13'd0)
			width_eff = 13'd1;
		else if (image_width_q > 13'(MAX_WIDTH))
			width_eff = 13'(MAX_WIDTH);
		else
			width_eff = image_width_q;
		if (image_height_q < 9'd2)
			height_eff = 9'd2;
		else if (image_height_q > 9'(MAX_HEIGHT))
			height_eff = 9'(MAX_HEIGHT);
		else
			height_eff = image_height_q;
	end

	assign col_last = 12'(width_eff - 13'd1);
	assign row_last = 8'(height_eff - 9'd1);

	// ---------------------------------------------------------------- state
	state_t             state_q, state_d;
	logic [11:0]        col_q;
	logic [7:0]         row_q;
	logic signed [15:0] sine_q;

	// latched item
	logic               nv_s1;
	logic signed [15:0] nz_s1;
	logic signed [15:0] rng_s1;

	// classification result
	logic               ground_q;
	logic [7:0]         pix_q;

	logic               result_valid_q;
	logic [7:0]         red_q, green_q, blue_q;
	logic               ground_flag_q, frame_end_q;

	logic pix_accept;
	logic out_free;
	logic row_end;
	logic last_row;

	assign pix_accept = pixel_valid && !pixel_stall;
	assign out_free   = !result_valid_q || !result_stall;
	assign row_end    = col_q >= col_last;
	assign last_row   = row_q >= row_last;

	// ------------------------------------------------------- shared divider
	div_req_t          div_req;
	unit_stat_t        div_stat;
	logic [DIV_W-1:0]  div_dividend;
	logic [DIVR_W-1:0] div_divisor;
	logic [DIV_W-1:0]  div_quot;

	lgoc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// ------------------------------------------------------------- CORDIC
	logic               cord_start;
	logic signed [31:0] cord_angle;
	unit_stat_t         cord_stat;
	logic signed [15:0] cord_sine;

	lgoc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cord_start),
		.angle  (cord_angle),
		.stat   (cord_stat),
		.sine   (cord_sine)
	);

	// Row angle = ANGLE_MIN + SPAN * r / (h - 1), r clamped to the last row.
	logic [7:0]       row_sel;
	logic [DIV_W-1:0] angle_prod;

	assign row_sel    = (row_q > row_last) ? row_last : row_q;
	assign angle_prod = DIV_W'(ANGLE_SPAN) * DIV_W'(row_sel);
	assign cord_angle = ANGLE_MIN + $signed({5'b0, div_quot[26:0]});

	// ---------------------------------------------------------- ground test
	// range * sine (Q9.23) against threshold scaled to the same point
	logic signed [31:0] height_prod;
	logic signed [31:0] height_lim;
	logic               ground_now;

	assign height_prod = rng_s1 * sine_q;
	assign height_lim  = $signed({ht_thresh_q[15], ht_thresh_q, 15'b0});
	assign ground_now  = nv_s1 && (nz_s1 >= nz_thresh_q) && (rng_s1 > 16'sd0)
		&& (height_prod <= height_lim);

	// ----------------------------------------------------------- normal grey
	// clamp(nz + 1.0, 0, 2.0) * 255 / 2^15, truncated
	logic signed [16:0] nz_off;
	logic [15:0]        nz_clamp;
	logic [23:0]        nz_scaled;
	logic [7:0]         nz_grey;

	assign nz_off = {nz_s1[15], nz_s1} + 17'sd16384;

	always_comb begin
		if (nz_off < 17'sd0)
			nz_clamp = 16'd0;
		else if (nz_off > 17'sd32768)
			nz_clamp = 16'd32768;
		else
			nz_clamp = nz_off[15:0];
	end

	assign nz_scaled = {nz_clamp, 8'b0} - {8'b0, nz_clamp};
	assign nz_grey   = nz_scaled[22:15];

	// ------------------------------------------------------------ range grey
	// norm = (span - (range - floor)) / span; span of zero reads as 1.0 m.
	// Negative span flips both signs so the divide stays unsigned.
	logic signed [16:0] den_raw;
	logic signed [19:0] den_nz;
	logic signed [16:0] rng_diff;
	logic signed [19:0] num_raw;
	logic signed [19:0] den_abs;
	logic signed [19:0] num_adj;
	logic [16:0]        num_u;
	logic [24:0]        num_scaled;

	assign den_raw  = {rng_ceil_q[15], rng_ceil_q} - {rng_floor_q[15], rng_floor_q};
	assign den_nz   = (den_raw == 17'sd0) ? 20'sd256 : {{3{den_raw[16]}}, den_raw};
	assign rng_diff = {rng_s1[15], rng_s1} - {rng_floor_q[15], rng_floor_q};
	assign num_raw  = den_nz - {{3{rng_diff[16]}}, rng_diff};
	assign den_abs  = den_nz[19] ? -den_nz : den_nz;
	assign num_adj  = den_nz[19] ? -num_raw : num_raw;
	assign num_u    = num_adj[16:0];
	assign num_scaled = {num_u, 8'b0} - {8'b0, num_u};

	// ----------------------------------------------------------- sequencer
	always_comb begin
		state_d       = state_q;
		pixel_stall   = 1'b1;
		div_req.start = 1'b0;
		div_req.steps = ANGLE_DIV_STEPS;
		div_dividend  = angle_prod;
		div_divisor   = DIVR_W'(row_last);
		cord_start    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pixel_stall = 1'b0;
				if (pixel_valid)
					state_d = (col_q == 12'd0) ? ST_ANG : ST_CLASS;
			end
			ST_ANG: begin
				div_req.start = 1'b1;
				state_d       = ST_ADIV;
			end
			ST_ADIV: begin
				if (div_stat.done) begin
					cord_start = 1'b1;
					state_d    = ST_CORD;
				end
			end
			ST_CORD: begin
				if (cord_stat.done)
					state_d = ST_CLASS;
			end
			ST_CLASS: begin
				state_d = ST_FIN;
				if (!ground_now && !nv_s1 && !rng_s1[15]
						&& (num_adj > 20'sd0) && (num_adj < den_abs)) begin
					div_req.start = 1'b1;
					div_req.steps = GREY_DIV_STEPS;
					div_dividend  = {num_scaled[23:0], 11'b0};
					div_divisor   = den_abs[16:0];
					state_d       = ST_GDIV;
				end
			end
			ST_GDIV: begin
				if (div_stat.done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// item and classification registers
	always_ff @(posedge clk) begin
		if (pix_accept) begin
			nv_s1  <= normal_valid;
			nz_s1  <= normal_z;
			rng_s1 <= range_value;
		end
		if (state_q == ST_ADIV || state_q == ST_CORD) begin
			if (cord_stat.done)
				sine_q <= cord_sine;
		end
		if (state_q == ST_CLASS) begin
			ground_q <= ground_now;
			if (ground_now)
				pix_q <= 8'd0;
			else if (nv_s1)
				pix_q <= nz_grey;
			else if (rng_s1[15] || num_adj <= 20'sd0)
				pix_q <= 8'd0;
			else
				pix_q <= 8'd255;
		end
		if (state_q == ST_GDIV && div_stat.done)
			pix_q <= div_quot[7:0];
	end

	// raster counters and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q          <= '0;
			row_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (!result_stall)
				result_valid_q <= 1'b0;
			if (state_q == ST_FIN && out_free) begin
				result_valid_q <= 1'b1;
				if (row_end) begin
					col_q <= '0;
					row_q <= last_row ? 8'd0 : row_q + 8'd1;
				end else begin
					col_q <= col_q + 12'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			red_q         <= ground_q ? 8'd255 : pix_q;
			green_q       <= ground_q ? 8'd165 : pix_q;
			blue_q        <= ground_q ? 8'd0   : pix_q;
			ground_flag_q <= ground_q;
			frame_end_q   <= row_end && last_row;
		end
	end

	assign result_valid = result_valid_q;
	assign red          = red_q;
	assign green        = green_q;
	assign blue         = blue_q;
	assign ground_flag  = ground_flag_q;
	assign frame_end    = frame_end_q;

`ifndef NO_ASSERTIONS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pix_accept |=> state_q != ST_IDLE)
		else $error("pixel accepted but sequencer stayed idle");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_ADIV || state_q == ST_GDIV))
		else $error("divider finished outside a divide state");

	a_cordic_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		cord_stat.done |-> state_q == ST_CORD)
		else $error("CORDIC finished outside its state");

	a_ground_colour: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && ground_flag |-> red == 8'd255 && green == 8'd165 && blue == 8'd0)
		else $error("ground item without orange");

	a_grey_colour: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !ground_flag |-> red == green && green == blue)
		else $error("non-ground item not grey");
`endif

endmodule

### verif/tb_lidar_ground_overlay_classifier_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lidar_ground_overlay_classifier_unit
// Drives range-image pixels through the ground overlay classifier and checks
// each overlay item against an in-bench predictor. The predictor keeps its own
// raster counters, register copies and per-row CORDIC sine. The run starts with
// directed frames for the edge cases, then moves on to random register
// settings with random pixel content. It uses bursty idling on both channels
// and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_lidar_ground_overlay_classifier_unit;
	import lgoc_pkg::*;

	localparam int  ITEM_TARGET    = 1100;
	localparam int  CALM_ITEMS     = 150;    // final stretch with no idling
	localparam int  HOLD_CYCLES    = 400;    // long output hold-off
	localparam int  TAIL_CYCLES    = 200;
	localparam int  WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all

	// angle start, span and CORDIC gain, Q3.28
	localparam longint ELEV_MIN_Q28  = -64'sd116658555;
	localparam longint ELEV_SPAN_Q28 = 64'sd126028720;
	localparam longint GAIN_Q28      = 64'sd163008219;

	localparam longint ARCTAN_Q28 [24] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
		4193963, 2097109, 1048571, 524287, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048,
		1024, 512, 256, 128, 64, 32
	};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       ground;
		logic       frame_end;
	} overlay_px_t;

	// ------------------------------------------------------------------------
	// Overlay predictor and pending-item store
	// ------------------------------------------------------------------------
	class overlay_scoreboard;
		int unsigned width_reg, height_reg;
		int          nz_thr, ht_thr, rng_floor, rng_ceil;
		int unsigned col, row;
		int          sine_q15;
		overlay_px_t expected_px[$];
		int unsigned mismatches;

		function new();
			width_reg  = 2048;
			height_reg = 64;
			nz_thr     = 14746;
			ht_thr     = -384;
			rng_floor  = 0;
			rng_ceil   = 25600;
			col        = 0;
			row        = 0;
			sine_q15   = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				REG_WIDTH:     width_reg  = data[12:0];
				REG_HEIGHT:    height_reg = data[8:0];
				REG_NZ_THRESH: nz_thr     = int'($signed(data));
				REG_HT_THRESH: ht_thr     = int'($signed(data));
				REG_RNG_FLOOR: rng_floor  = int'($signed(data));
				REG_RNG_CEIL:  rng_ceil   = int'($signed(data));
				default: ;
			endcase
		endfunction

		// sine of the row elevation, Q1.15
		function int elevation_sine(int unsigned row_idx, int unsigned rows);
			longint unsigned step_q28;
			longint          z, x, y, dx, dy;
			int unsigned     r;
			r = (row_idx > rows - 1) ? rows - 1 : row_idx;
			step_q28 = (longint'(ELEV_SPAN_Q28) * r) / (rows - 1);
			z = ELEV_MIN_Q28 + longint'(step_q28);
			x = GAIN_Q28;
			y = 0;
			for (int i = 0; i < SINE_ITERATIONS && i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= ARCTAN_Q28[i];
				end else begin
					x += dx;
					y -= dy;
					z += ARCTAN_Q28[i];
				end
			end
			y = (y + 4096) >>> 13;
			if (y > 32767)
				y = 32767;
			if (y < -32768)
				y = -32768;
			return int'(y);
		endfunction

		function void note_pixel(logic nv, logic [15:0] nz_raw, logic [15:0] rng_raw);
			int unsigned w, h, pix;
			int          nz, rng, v;
			bit          ground, row_end, last_row;
			longint      den, num;
			overlay_px_t px;
			w = width_reg;
			if (w < 1)
				w = 1;
			if (w > MAX_WIDTH)
				w = MAX_WIDTH;
			h = height_reg;
			if (h < 2)
				h = 2;
			if (h > MAX_HEIGHT)
				h = MAX_HEIGHT;
			nz  = int'($signed(nz_raw));
			rng = int'($signed(rng_raw));

			if (col == 0)
				sine_q15 = elevation_sine(row, h);

			ground = 0;
			if (nv && nz >= nz_thr && rng > 0)
				if (longint'(rng) * sine_q15 <= longint'(ht_thr) * 32768)
					ground = 1;

			pix = 0;
			if (nv) begin
				v = nz + 16384;
				if (v < 0)
					v = 0;
				if (v > 32768)
					v = 32768;
				pix = (v * 255) / 32768;
			end else if (rng >= 0) begin
				den = longint'(rng_ceil) - rng_floor;
				if (den == 0)
					den = 256;
				num = den - (longint'(rng) - rng_floor);
				if (den < 0) begin
					den = -den;
					num = -num;
				end
				if (num <= 0)
					pix = 0;
				else if (num >= den)
					pix = 255;
				else
					pix = int'((num * 255) / den);
			end

			row_end  = col >= w - 1;
			last_row = row >= h - 1;

			px.red       = ground ? 8'd255 : 8'(pix);
			px.green     = ground ? 8'd165 : 8'(pix);
			px.blue      = ground ? 8'd0   : 8'(pix);
			px.ground    = ground;
			px.frame_end = row_end && last_row;
			expected_px.push_back(px);

			if (row_end) begin
				col = 0;
				row = last_row ? 0 : row + 1;
			end else begin
				col++;
			end
		endfunction

		task report(string msg);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		function int unsigned pending();
			return expected_px.size();
		endfunction

		task check_result(overlay_px_t got);
			overlay_px_t want;
			if (expected_px.size() == 0) begin
				report($sformatf("item with nothing pending (rgb %0d,%0d,%0d)",
					got.red, got.green, got.blue));
				return;
			end
			want = expected_px.pop_front();
			if (got.red !== want.red)
				report($sformatf("red got %0d want %0d", got.red, want.red));
			if (got.green !== want.green)
				report($sformatf("green got %0d want %0d", got.green, want.green));
			if (got.blue !== want.blue)
				report($sformatf("blue got %0d want %0d", got.blue, want.blue));
			if (got.ground !== want.ground)
				report($sformatf("ground_flag got %b want %b", got.ground, want.ground));
			if (got.frame_end !== want.frame_end)
				report($sformatf("frame_end got %b want %b", got.frame_end, want.frame_end));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic               clk;
	logic               arst_n;
	logic               pixel_valid;
	logic               pixel_stall;
	logic               normal_valid;
	logic signed [15:0] normal_z;
	logic signed [15:0] range_value;
	logic               result_valid;
	logic               result_stall;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               ground_flag;
	logic               frame_end;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	lidar_ground_overlay_classifier_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.normal_valid (normal_valid),
		.normal_z     (normal_z),
		.range_value  (range_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.ground_flag  (ground_flag),
		.frame_end    (frame_end),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	overlay_scoreboard board;
	int unsigned       pixels_sent;
	int unsigned       quiet_cycles;
	bit                idle_on;        // random idling on both sides
	bit                hold_request;   // asks the receiver for the long hold-off

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Result side: every accepted item goes to the scoreboard
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			board.check_result(overlay_px_t'({red, green, blue, ground_flag, frame_end}));
	end

	// Receiver stall pattern: bursts of stall, open stretches, and once a long
	// hold-off so the block backs up into the pixel channel.
	initial begin
		result_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 2) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Watchdog: any handshake restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Drivers; every task is entered right after a rising edge
	// ------------------------------------------------------------------------
	function automatic int rand_between(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// Leaves cfg_valid high so back-to-back writes never toggle it in one step.
	task automatic write_cfg(input logic [2:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_reg(idx, data);
	endtask

	task automatic program_regs(input logic [15:0] w, input logic [15:0] h,
	                            input logic [15:0] nzt, input logic [15:0] htt,
	                            input logic [15:0] flo, input logic [15:0] cei,
	                            input logic [5:0] mask);
		if (mask[REG_WIDTH])
			write_cfg(REG_WIDTH, w);
		if (mask[REG_HEIGHT])
			write_cfg(REG_HEIGHT, h);
		if (mask[REG_NZ_THRESH])
			write_cfg(REG_NZ_THRESH, nzt);
		if (mask[REG_HT_THRESH])
			write_cfg(REG_HT_THRESH, htt);
		if (mask[REG_RNG_FLOOR])
			write_cfg(REG_RNG_FLOOR, flo);
		if (mask[REG_RNG_CEIL])
			write_cfg(REG_RNG_CEIL, cei);
		if (mask != '0)
			cfg_valid <= 1'b0;
	endtask

	// Offer one pixel, optionally after an idle gap; returns at the accept edge
	// with pixel_valid still high.
	task automatic drive_pixel(input logic nv, input logic [15:0] nz,
	                           input logic [15:0] rv);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		pixel_valid  <= 1'b1;
		normal_valid <= nv;
		normal_z     <= nz;
		range_value  <= rv;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		board.note_pixel(nv, nz, rv);
		pixels_sent++;
	endtask

	// Block is idle once every pending overlay item has come out
	task automatic wait_idle();
		while (board.pending() != 0) @(posedge clk);
	endtask

	// Random pixel, biased toward ground candidates under the current thresholds
	task automatic random_pixel();
		int   kind, lo, hi;
		logic nv;
		int   nz, rv;
		kind = rand_between(0, 9);
		nz   = rand_between(-16384, 16384);
		rv   = int'($signed(16'($urandom)));
		if (kind < 5) begin
			nv = 1'b1;
			if (board.nz_thr <= 16384)
				nz = rand_between((board.nz_thr < -16384) ? -16384 : board.nz_thr, 16384);
			rv = rand_between(1, 32767);
		end else if (kind < 7) begin
			nv = 1'b1;
		end else if (kind < 9) begin
			nv = 1'b0;
			lo = (board.rng_floor < board.rng_ceil) ? board.rng_floor : board.rng_ceil;
			hi = (board.rng_floor < board.rng_ceil) ? board.rng_ceil : board.rng_floor;
			lo = (lo - 500 < -32768) ? -32768 : lo - 500;
			hi = (hi + 500 > 32767) ? 32767 : hi + 500;
			rv = rand_between(lo, hi);
		end else begin
			nv = 1'b0;
			case (rand_between(0, 4))
				0: rv = 0;
				1: rv = -1;
				2: rv = -32768;
				3: rv = 32767;
				default: rv = rand_between(-32768, -1);
			endcase
		end
		drive_pixel(nv, 16'(nz), 16'(rv));
	endtask

	task automatic random_config(input bit all_regs);
		logic [15:0] w, h, nzt, htt, flo, cei;
		logic [5:0]  mask;
		int          pick;
		pick = rand_between(0, 9);
		if (pick < 7)
			w = 16'(rand_between(1, 6));
		else if (pick < 8)
			w = 16'(rand_between(7, 40));
		else
			case (rand_between(0, 3))
				0: w = 16'd0;
				1: w = 16'd4096;
				2: w = 16'd8191;
				default: w = 16'd1;
			endcase
		pick = rand_between(0, 9);
		if (pick < 7)
			h = 16'(rand_between(2, 5));
		else if (pick < 8)
			h = 16'(rand_between(6, 20));
		else
			case (rand_between(0, 3))
				0: h = 16'd0;
				1: h = 16'd1;
				2: h = 16'd256;
				default: h = 16'd511;
			endcase
		pick = rand_between(0, 9);
		if (pick < 5)
			nzt = 16'(rand_between(12000, 16384));
		else if (pick < 8)
			nzt = 16'(rand_between(-16384, 16384));
		else
			nzt = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
		pick = rand_between(0, 9);
		if (pick < 5)
			htt = 16'(rand_between(-2000, 500));
		else if (pick < 8)
			htt = 16'($urandom);
		else
			htt = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
		pick = rand_between(0, 9);
		if (pick < 6) begin
			flo = 16'(rand_between(0, 2000));
			cei = 16'(rand_between(5000, 30000));
		end else if (pick < 8) begin
			flo = 16'($urandom);
			cei = 16'($urandom);
		end else if (pick < 9) begin
			// zero span, treated as one metre
			flo = 16'($urandom);
			cei = flo;
		end else if ($urandom_range(0, 1)) begin
			flo = 16'h8000;
			cei = 16'h7fff;
		end else begin
			flo = 16'h7fff;
			cei = 16'h8000;
		end
		mask = all_regs ? '1 : 6'($urandom_range(0, 63));
		program_regs(w, h, nzt, htt, flo, cei, mask);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int          phase, count;
		logic [5:0]  size_mask;
		board        = new();
		pixels_sent  = 0;
		quiet_cycles = 0;
		idle_on      = 1'b1;
		hold_request = 1'b0;
		arst_n       <= 1'b0;
		pixel_valid  <= 1'b0;
		normal_valid <= 1'b0;
		normal_z     <= '0;
		range_value  <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= REG_WIDTH;
		cfg_data     <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		size_mask = '0;
		size_mask[REG_WIDTH]  = 1'b1;
		size_mask[REG_HEIGHT] = 1'b1;

		// reset settings: ground at full range, threshold nz with tiny range,
		// zero range with a normal, black for negative range, white at zero range
		drive_pixel(1'b1, 16'sd16384, 16'sd32767);
		drive_pixel(1'b1, 16'sd14746, 16'sd1);
		drive_pixel(1'b1, -16'sd16384, 16'sd0);
		drive_pixel(1'b0, 16'sd0, -16'sd32768);
		drive_pixel(1'b0, -16'sd1, 16'sd0);
		pixel_valid <= 1'b0;
		wait_idle();

		// 3x2 frame, zero range span, loosest height limit, strictest nz
		program_regs(16'd3, 16'd2, 16'sd16384, 16'h7fff, 16'sd1000, 16'sd1000, '1);
		drive_pixel(1'b1, 16'sd16384, 16'sd1);
		drive_pixel(1'b0, 16'sd0, 16'sd1000);
		drive_pixel(1'b0, 16'sd0, 16'sd1128);
		drive_pixel(1'b0, 16'sd0, 16'sd1256);
		drive_pixel(1'b0, 16'sd0, 16'sd872);
		drive_pixel(1'b0, 16'sd0, 16'sd32767);
		drive_pixel(1'b0, 16'sd0, -16'sd1);
		pixel_valid <= 1'b0;
		wait_idle();

		// width 0 and height 1 clamp up, inverted range span, extreme thresholds
		program_regs(16'd0, 16'd1, -16'sd16384, 16'h8000, 16'sd20000, -16'sd20000, '1);
		drive_pixel(1'b0, 16'sd0, 16'sd0);
		drive_pixel(1'b0, 16'sd0, 16'sd20000);
		drive_pixel(1'b0, 16'sd0, -16'sd20000);
		drive_pixel(1'b0, 16'sd0, 16'sd5);
		drive_pixel(1'b1, -16'sd16384, 16'sd32767);
		pixel_valid <= 1'b0;
		wait_idle();

		// oversized width and height clamp down, widest range span
		program_regs(16'd8191, 16'd511, 16'sd0, 16'sd0, 16'h8000, 16'h7fff, '1);
		drive_pixel(1'b1, 16'sd0, 16'sd100);
		drive_pixel(1'b1, -16'sd1, 16'sd100);
		drive_pixel(1'b0, 16'sd0, 16'sd0);
		pixel_valid <= 1'b0;
		wait_idle();

		// shrink the image mid-row: column past the end closes the row, sine kept
		program_regs(16'd2, 16'd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0, size_mask);
		drive_pixel(1'b1, 16'sd8000, 16'sd3000);
		drive_pixel(1'b1, 16'sd8000, 16'sd3000);
		drive_pixel(1'b1, 16'sd8000, 16'sd3000);
		drive_pixel(1'b0, 16'sd0, 16'sd3000);
		pixel_valid <= 1'b0;

		// random settings and pixels
		phase = 0;
		while (pixels_sent < ITEM_TARGET) begin
			wait_idle();
			if (phase == 4) begin
				// one tall, one-pixel-wide image: every pixel starts a row
				program_regs(16'd1, 16'd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, size_mask);
				count = 257;
			end else begin
				random_config(phase == 0);
				count = rand_between(20, 70);
			end
			idle_on = (pixels_sent + CALM_ITEMS < ITEM_TARGET) && phase != 2;
			if (phase == 2)
				hold_request = 1'b1;
			repeat (count) random_pixel();
			pixel_valid <= 1'b0;
			phase++;
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.pending() != 0)
			board.report($sformatf("%0d overlay items never came out", board.pending()));
		if (board.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### filelist.f
rtl/lgoc_pkg.sv
rtl/lgoc_div.sv
rtl/lgoc_cordic.sv
rtl/lidar_ground_overlay_classifier_unit.sv
verif/tb_lidar_ground_overlay_classifier_unit.sv
